// ===== hdl/ktpb_pkg.sv =====
// Package for the tilt Kalman filter and balance PID block.
// Holds data widths, register indexes, reset values and the sequencer state type.
// No dependencies.
package ktpb_pkg;

    localparam int DW = 32;
    localparam int CW = 31;
    localparam int LIM_W = 15;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_KP        = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI        = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD        = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_Q_ANGLE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_Q_GYRO    = 3'd5;
    localparam logic [IDX_W-1:0] REG_R_ANGLE   = 3'd6;
    localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd7;

    localparam logic [CW-1:0]    KP_RST     = 31'd21626880;
    localparam logic [CW-1:0]    KI_RST     = 31'd1654784;
    localparam logic [CW-1:0]    KD_RST     = 31'd75366400;
    localparam logic [LIM_W-1:0] LIMIT_RST  = 15'd1000;
    localparam logic [CW-1:0]    QA_RST     = 31'd1073742;
    localparam logic [CW-1:0]    QG_RST     = 31'd3221225;
    localparam logic [CW-1:0]    RA_RST     = 31'd536870912;
    localparam logic [CW-1:0]    DT_RST     = 31'd10737418;
    localparam logic [DW-1:0]    ONE_Q30    = 32'h4000_0000;
    localparam logic [DW-1:0]    BAND_Q16   = 32'h0005_0000;

    localparam logic [3:0] STEP_P11_PRED = 4'd4;
    localparam logic [3:0] STEP_CORR0    = 4'd5;
    localparam logic [3:0] STEP_PROP     = 4'd11;
    localparam logic [3:0] STEP_DERIV    = 4'd12;
    localparam logic [3:0] STEP_INTEG    = 4'd13;
    localparam logic [5:0] DIV_LAST      = 6'd61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_PREP,
        ST_DLOAD,
        ST_DIV,
        ST_DSTORE,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/kalman_tilt_pid_balance_top.sv =====
// Top level of the tilt Kalman filter and balance PID block.
// Depends on ktpb_pkg for widths, register indexes, reset values and state type.
//
// A sample runs through fourteen multiply-accumulate steps, each a multiply
// and an accumulate state, on one shared 33x32 multiplier, two 62-step
// restoring divisions for the Kalman gains (each with a load and a store
// state), a setup state and an output state. The input is stalled while a
// sample is in work, so the next input beat can be taken in the cycle after
// the result is loaded; the result sits in an output register, so a new
// sample can enter while it waits. Configuration must be written through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce this.
module kalman_tilt_pid_balance_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ktpb_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ktpb_pkg::CW-1:0]         cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [ktpb_pkg::DW-1:0]  accel_angle,
    input  logic signed [ktpb_pkg::DW-1:0]  gyro_rate,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [15:0]              drive,
    output logic signed [ktpb_pkg::DW-1:0]  filtered_angle,
    output logic signed [ktpb_pkg::DW-1:0]  rate_estimate
);

    function automatic logic signed [67:0] ext32(input logic signed [31:0] v);
        return {{36{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = $signed({36'd0, 32'h7FFF_FFFF});
        lo = $signed({{36{1'b1}}, 32'h8000_0000});
        if (v > hi)
            return hi[31:0];
        else if (v < lo)
            return lo[31:0];
        else
            return v[31:0];
    endfunction

    function automatic logic signed [64:0] shr_tz(input logic signed [64:0] v,
                                                   input logic [4:0] s);
        logic signed [64:0] rnd;
        rnd = v[64] ? ((65'sd1 <<< s) - 65'sd1) : 65'sd0;
        return (v + rnd) >>> s;
    endfunction

    ktpb_pkg::state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        sel_reg, sel_next;

    logic [ktpb_pkg::CW-1:0]    kp_reg, kp_next, ki_reg, ki_next, kd_reg, kd_next;
    logic [ktpb_pkg::LIM_W-1:0] lim_reg, lim_next;
    logic [ktpb_pkg::CW-1:0]    qa_reg, qa_next, qg_reg, qg_next;
    logic [ktpb_pkg::CW-1:0]    ra_reg, ra_next, dt_reg, dt_next;

    logic signed [31:0] ang_reg, ang_next, bias_reg, bias_next;
    logic signed [31:0] p00_reg, p00_next, p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next, p11_reg, p11_next;
    logic signed [31:0] perr_reg, perr_next, integ_reg, integ_next;
    logic signed [31:0] accel_reg, accel_next, gyro_reg, gyro_next;
    logic signed [31:0] inn_reg, inn_next, t0_reg, t0_next, t1_reg, t1_next;
    logic signed [31:0] k0_reg, k0_next, k1_reg, k1_next;
    logic signed [32:0] e_reg, e_next;
    logic signed [64:0] prod_reg, prod_next;
    logic signed [47:0] prop_reg, prop_next, deriv_reg, deriv_next;
    logic [31:0]        rem_reg, rem_next;
    logic [61:0]        quo_reg, quo_next;

    logic               ov_reg, ov_next;
    logic signed [15:0] drive_reg, drive_next;
    logic signed [31:0] fang_reg, fang_next, rate_reg, rate_next;

    logic signed [32:0] op_a;
    logic signed [31:0] op_b;
    logic signed [64:0] sh;
    logic signed [31:0] lim_q;
    logic signed [31:0] tmp;
    logic signed [31:0] num;
    logic [31:0]        nmag;
    logic [31:0]        dmag;
    logic [33:0]        trial;
    logic signed [49:0] sum;
    logic signed [31:0] sum_cl;
    logic signed [32:0] sum_rnd;
    logic               near;

    assign in_stall       = (state_reg != ktpb_pkg::ST_IDLE);
    assign out_valid      = ov_reg;
    assign drive          = drive_reg;
    assign filtered_angle = fang_reg;
    assign rate_estimate  = rate_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        kp_next    = kp_reg;
        ki_next    = ki_reg;
        kd_next    = kd_reg;
        lim_next   = lim_reg;
        qa_next    = qa_reg;
        qg_next    = qg_reg;
        ra_next    = ra_reg;
        dt_next    = dt_reg;
        ang_next   = ang_reg;
        bias_next  = bias_reg;
        p00_next   = p00_reg;
        p01_next   = p01_reg;
        p10_next   = p10_reg;
        p11_next   = p11_reg;
        perr_next  = perr_reg;
        integ_next = integ_reg;
        accel_next = accel_reg;
        gyro_next  = gyro_reg;
        inn_next   = inn_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        e_next     = e_reg;
        prod_next  = prod_reg;
        prop_next  = prop_reg;
        deriv_next = deriv_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        ov_next    = ov_reg;
        drive_next = drive_reg;
        fang_next  = fang_reg;
        rate_next  = rate_reg;

        op_a  = 33'sd0;
        op_b  = 32'sd0;
        sh    = 65'sd0;
        tmp   = 32'sd0;
        lim_q = $signed({1'b0, lim_reg, 16'd0});
        near  = (ang_reg <= $signed(ktpb_pkg::BAND_Q16))
                && (ang_reg >= -$signed(ktpb_pkg::BAND_Q16));
        num   = sel_reg ? p10_reg : p00_reg;
        nmag  = num[31] ? 32'(-num) : 32'(num);
        dmag  = e_reg[32] ? 32'(-e_reg) : 32'(e_reg);
        trial = {1'b0, rem_reg, quo_reg[61]} - {2'b00, dmag};
        sum   = 50'(prop_reg) + 50'(deriv_reg) + 50'(integ_reg);
        if (sum < -50'(lim_q))
            sum_cl = -lim_q;
        else if (sum >= 50'(lim_q))
            sum_cl = lim_q;
        else
            sum_cl = sum[31:0];
        sum_rnd = sum_cl[31] ? (33'(sum_cl) + 33'sd65535) : 33'(sum_cl);

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                ktpb_pkg::REG_KP:        kp_next  = cfg_data;
                ktpb_pkg::REG_KI:        ki_next  = cfg_data;
                ktpb_pkg::REG_KD:        kd_next  = cfg_data;
                ktpb_pkg::REG_LIMIT:     lim_next = cfg_data[ktpb_pkg::LIM_W-1:0];
                ktpb_pkg::REG_Q_ANGLE:   qa_next  = cfg_data;
                ktpb_pkg::REG_Q_GYRO:    qg_next  = cfg_data;
                ktpb_pkg::REG_R_ANGLE:   ra_next  = cfg_data;
                ktpb_pkg::REG_TIME_STEP: dt_next  = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ktpb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    accel_next = accel_angle;
                    gyro_next  = gyro_rate;
                    step_next  = 4'd0;
                    state_next = ktpb_pkg::ST_MUL;
                end
            end
            ktpb_pkg::ST_MUL:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        op_a = 33'(gyro_reg) - 33'(bias_reg);
                        op_b = $signed({1'b0, dt_reg});
                    end
                    4'd1:
                    begin
                        op_a = 33'(sat32($signed({37'd0, qa_reg}) - ext32(p01_reg)
                                             - ext32(p10_reg)));
                        op_b = $signed({1'b0, dt_reg});
                    end
                    4'd2, 4'd3:
                    begin
                        op_a = 33'(sat32(-ext32(p11_reg)));
                        op_b = $signed({1'b0, dt_reg});
                    end
                    4'd4:
                    begin
                        op_a = $signed({2'b00, qg_reg});
                        op_b = $signed({1'b0, dt_reg});
                    end
                    4'd5:
                    begin
                        op_a = 33'(t0_reg);
                        op_b = k0_reg;
                    end
                    4'd6:
                    begin
                        op_a = 33'(t1_reg);
                        op_b = k0_reg;
                    end
                    4'd7:
                    begin
                        op_a = 33'(t0_reg);
                        op_b = k1_reg;
                    end
                    4'd8:
                    begin
                        op_a = 33'(t1_reg);
                        op_b = k1_reg;
                    end
                    4'd9:
                    begin
                        op_a = 33'(inn_reg);
                        op_b = k0_reg;
                    end
                    4'd10:
                    begin
                        op_a = 33'(inn_reg);
                        op_b = k1_reg;
                    end
                    4'd11:
                    begin
                        op_a = 33'(ang_reg);
                        op_b = $signed({1'b0, kp_reg});
                    end
                    4'd12:
                    begin
                        op_a = 33'(sat32(ext32(ang_reg) - ext32(perr_reg)));
                        op_b = $signed({1'b0, kd_reg});
                    end
                    default:
                    begin
                        op_a = 33'(ang_reg);
                        op_b = $signed({1'b0, ki_reg});
                    end
                endcase
                prod_next  = 65'(op_a) * 65'(op_b);
                state_next = ktpb_pkg::ST_ACC;
            end
            ktpb_pkg::ST_ACC:
            begin
                if (step_reg == ktpb_pkg::STEP_PROP || step_reg == ktpb_pkg::STEP_DERIV
                    || (step_reg == ktpb_pkg::STEP_INTEG && near))
                    sh = shr_tz(prod_reg, 5'd16);
                else if (step_reg == ktpb_pkg::STEP_INTEG)
                    sh = shr_tz(prod_reg, 5'd17);
                else
                    sh = shr_tz(prod_reg, 5'd30);
                case (step_reg)
                    4'd0:  ang_next  = sat32(ext32(ang_reg) + 68'(sh));
                    4'd1:  p00_next  = sat32(ext32(p00_reg) + 68'(sh));
                    4'd2:  p01_next  = sat32(ext32(p01_reg) + 68'(sh));
                    4'd3:  p10_next  = sat32(ext32(p10_reg) + 68'(sh));
                    4'd4:  p11_next  = sat32(ext32(p11_reg) + 68'(sh));
                    4'd5:  p00_next  = sat32(ext32(p00_reg) - 68'(sh));
                    4'd6:  p01_next  = sat32(ext32(p01_reg) - 68'(sh));
                    4'd7:  p10_next  = sat32(ext32(p10_reg) - 68'(sh));
                    4'd8:  p11_next  = sat32(ext32(p11_reg) - 68'(sh));
                    4'd9:  ang_next  = sat32(ext32(ang_reg) + 68'(sh));
                    4'd10: bias_next = sat32(ext32(bias_reg) + 68'(sh));
                    4'd11: prop_next = sh[47:0];
                    4'd12: deriv_next = sh[47:0];
                    default:
                    begin
                        tmp = sat32(ext32(integ_reg) + 68'(sh));
                        if (near && tmp > lim_q)
                            integ_next = lim_q;
                        else if (near && tmp < -lim_q)
                            integ_next = -lim_q;
                        else
                            integ_next = tmp;
                    end
                endcase
                if (step_reg == ktpb_pkg::STEP_P11_PRED)
                    state_next = ktpb_pkg::ST_PREP;
                else if (step_reg == ktpb_pkg::STEP_INTEG)
                    state_next = ktpb_pkg::ST_DONE;
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = ktpb_pkg::ST_MUL;
                end
            end
            ktpb_pkg::ST_PREP:
            begin
                inn_next   = sat32(ext32(accel_reg) - ext32(ang_reg));
                e_next     = $signed({2'b00, ra_reg}) + 33'(p00_reg);
                t0_next    = p00_reg;
                t1_next    = p01_reg;
                sel_next   = 1'b0;
                state_next = ktpb_pkg::ST_DLOAD;
            end
            ktpb_pkg::ST_DLOAD:
            begin
                rem_next   = 32'd0;
                quo_next   = {nmag, 30'd0};
                cnt_next   = 6'd0;
                state_next = ktpb_pkg::ST_DIV;
            end
            ktpb_pkg::ST_DIV:
            begin
                quo_next = {quo_reg[60:0], !trial[33]};
                rem_next = trial[33] ? {rem_reg[30:0], quo_reg[61]} : trial[31:0];
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == ktpb_pkg::DIV_LAST)
                    state_next = ktpb_pkg::ST_DSTORE;
            end
            ktpb_pkg::ST_DSTORE:
            begin
                if (e_reg == 33'sd0)
                    tmp = 32'sd0;
                else if (num[31] ^ e_reg[32])
                    tmp = (quo_reg > 62'h8000_0000) ? 32'sh8000_0000 : 32'(-quo_reg[31:0]);
                else
                    tmp = (quo_reg > 62'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_reg[31:0];
                if (sel_reg)
                begin
                    k1_next    = tmp;
                    step_next  = ktpb_pkg::STEP_CORR0;
                    state_next = ktpb_pkg::ST_MUL;
                end
                else
                begin
                    k0_next    = tmp;
                    sel_next   = 1'b1;
                    state_next = ktpb_pkg::ST_DLOAD;
                end
            end
            ktpb_pkg::ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    drive_next = sum_rnd[31:16];
                    fang_next  = ang_reg;
                    rate_next  = sat32(ext32(gyro_reg) - ext32(bias_reg));
                    perr_next  = ang_reg;
                    state_next = ktpb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ktpb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ktpb_pkg::ST_IDLE;
            step_reg  <= 4'd0;
            cnt_reg   <= 6'd0;
            sel_reg   <= 1'b0;
            kp_reg    <= ktpb_pkg::KP_RST;
            ki_reg    <= ktpb_pkg::KI_RST;
            kd_reg    <= ktpb_pkg::KD_RST;
            lim_reg   <= ktpb_pkg::LIMIT_RST;
            qa_reg    <= ktpb_pkg::QA_RST;
            qg_reg    <= ktpb_pkg::QG_RST;
            ra_reg    <= ktpb_pkg::RA_RST;
            dt_reg    <= ktpb_pkg::DT_RST;
            ang_reg   <= 32'sd0;
            bias_reg  <= 32'sd0;
            p00_reg   <= $signed(ktpb_pkg::ONE_Q30);
            p01_reg   <= 32'sd0;
            p10_reg   <= 32'sd0;
            p11_reg   <= $signed(ktpb_pkg::ONE_Q30);
            perr_reg  <= 32'sd0;
            integ_reg <= 32'sd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            kp_reg    <= kp_next;
            ki_reg    <= ki_next;
            kd_reg    <= kd_next;
            lim_reg   <= lim_next;
            qa_reg    <= qa_next;
            qg_reg    <= qg_next;
            ra_reg    <= ra_next;
            dt_reg    <= dt_next;
            ang_reg   <= ang_next;
            bias_reg  <= bias_next;
            p00_reg   <= p00_next;
            p01_reg   <= p01_next;
            p10_reg   <= p10_next;
            p11_reg   <= p11_next;
            perr_reg  <= perr_next;
            integ_reg <= integ_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accel_reg <= accel_next;
        gyro_reg  <= gyro_next;
        inn_reg   <= inn_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        e_reg     <= e_next;
        prod_reg  <= prod_next;
        prop_reg  <= prop_next;
        deriv_reg <= deriv_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        drive_reg <= drive_next;
        fang_reg  <= fang_next;
        rate_reg  <= rate_next;
    end

endmodule

// ===== tb/sv/kalman_tilt_pid_balance_top_tb.sv =====
// Self-checking testbench for the tilt Kalman filter and balance PID block.
// Drives samples and register writes, predicts every result, checks each result beat.
// Depends on ktpb_pkg and kalman_tilt_pid_balance_top.
module kalman_tilt_pid_balance_top_tb;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  SETTLE       = 250;
    localparam longint SMAX      = (longint'(1) <<< (ktpb_pkg::DW - 1)) - 1;
    localparam longint SMIN      = -SMAX - 1;
    localparam longint Q30       = longint'(1) <<< 30;
    localparam longint BAND      = longint'(5) <<< 16;

    typedef enum logic [1:0] { K_SAMPLE, K_CFG, K_DRAIN } job_kind_t;

    typedef struct {
        job_kind_t                   kind;
        logic [ktpb_pkg::DW-1:0]     accel;
        logic [ktpb_pkg::DW-1:0]     gyro;
        logic [ktpb_pkg::IDX_W-1:0]  idx;
        logic [ktpb_pkg::CW-1:0]     data;
    } job_t;

    typedef struct {
        logic [15:0]             drive;
        logic [ktpb_pkg::DW-1:0] angle;
        logic [ktpb_pkg::DW-1:0] rate;
    } tilt_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [ktpb_pkg::IDX_W-1:0]      cfg_index = '0;
    logic [ktpb_pkg::CW-1:0]         cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic signed [ktpb_pkg::DW-1:0]  accel_angle = '0;
    logic signed [ktpb_pkg::DW-1:0]  gyro_rate = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic signed [15:0]              drive;
    logic signed [ktpb_pkg::DW-1:0]  filtered_angle;
    logic signed [ktpb_pkg::DW-1:0]  rate_estimate;

    job_t         pending[$];
    tilt_result_t expected_results[$];
    int           errors = 0;
    int           cycles = 0;
    int           sent = 0;
    int           rcvd = 0;

    longint m_kp, m_ki, m_kd, m_limit, m_qa, m_qg, m_ra, m_dt;
    longint m_angle, m_bias, m_prev_err, m_integ;
    longint m_cov[4];

    kalman_tilt_pid_balance_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .accel_angle    (accel_angle),
        .gyro_rate      (gyro_rate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .filtered_angle (filtered_angle),
        .rate_estimate  (rate_estimate)
    );

    always #1 clk = ~clk;

    function automatic longint sat(input longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint shr_tz(input longint v, input int s);
        if (v >= 0) return v >>> s;
        return -((-v) >>> s);
    endfunction

    task automatic apply_cfg(input logic [ktpb_pkg::IDX_W-1:0] idx,
                             input logic [ktpb_pkg::CW-1:0] data);
        case (idx)
            ktpb_pkg::REG_KP:        m_kp = data;
            ktpb_pkg::REG_KI:        m_ki = data;
            ktpb_pkg::REG_KD:        m_kd = data;
            ktpb_pkg::REG_LIMIT:     m_limit = data[ktpb_pkg::LIM_W-1:0];
            ktpb_pkg::REG_Q_ANGLE:   m_qa = data;
            ktpb_pkg::REG_Q_GYRO:    m_qg = data;
            ktpb_pkg::REG_R_ANGLE:   m_ra = data;
            ktpb_pkg::REG_TIME_STEP: m_dt = data;
            default: ;
        endcase
    endtask

    task automatic reset_model();
        m_kp = ktpb_pkg::KP_RST; m_ki = ktpb_pkg::KI_RST;
        m_kd = ktpb_pkg::KD_RST; m_limit = ktpb_pkg::LIMIT_RST;
        m_qa = ktpb_pkg::QA_RST; m_qg = ktpb_pkg::QG_RST;
        m_ra = ktpb_pkg::RA_RST; m_dt = ktpb_pkg::DT_RST;
        m_angle = 0; m_bias = 0; m_prev_err = 0; m_integ = 0;
        m_cov[0] = Q30; m_cov[1] = 0; m_cov[2] = 0; m_cov[3] = Q30;
    endtask

    task automatic predict_tilt(input logic signed [ktpb_pkg::DW-1:0] a_in,
                                input logic signed [ktpb_pkg::DW-1:0] g_in);
        longint a, g, p00, p01, p10, p11, d0, d1, inn, e, k0, k1;
        longint err, diff, prop, deriv, lim, sum, rate;
        tilt_result_t r;
        a = a_in;
        g = g_in;
        p00 = m_cov[0]; p01 = m_cov[1]; p10 = m_cov[2]; p11 = m_cov[3];
        m_angle = sat(m_angle + shr_tz((g - m_bias) * m_dt, 30));
        d0 = sat(m_qa - p01 - p10);
        d1 = sat(-p11);
        p00 = sat(p00 + shr_tz(d0 * m_dt, 30));
        p01 = sat(p01 + shr_tz(d1 * m_dt, 30));
        p10 = sat(p10 + shr_tz(d1 * m_dt, 30));
        p11 = sat(p11 + shr_tz(m_qg * m_dt, 30));
        inn = sat(a - m_angle);
        e = m_ra + p00;
        if (e == 0)
        begin
            k0 = 0;
            k1 = 0;
        end
        else
        begin
            k0 = sat((p00 * Q30) / e);
            k1 = sat((p10 * Q30) / e);
        end
        m_cov[0] = sat(p00 - shr_tz(k0 * p00, 30));
        m_cov[1] = sat(p01 - shr_tz(k0 * p01, 30));
        m_cov[2] = sat(p10 - shr_tz(k1 * p00, 30));
        m_cov[3] = sat(p11 - shr_tz(k1 * p01, 30));
        m_angle = sat(m_angle + shr_tz(k0 * inn, 30));
        m_bias = sat(m_bias + shr_tz(k1 * inn, 30));
        rate = sat(g - m_bias);
        err = m_angle;
        lim = m_limit <<< 16;
        prop = shr_tz(m_kp * err, 16);
        diff = sat(err - m_prev_err);
        deriv = shr_tz(m_kd * diff, 16);
        if (err <= BAND && err >= -BAND)
        begin
            m_integ = sat(m_integ + shr_tz(m_ki * err, 16));
            if (m_integ > lim) m_integ = lim;
            else if (m_integ < -lim) m_integ = -lim;
        end
        else
        begin
            m_integ = sat(m_integ + shr_tz(m_ki * err, 17));
        end
        sum = prop + m_integ + deriv;
        if (sum < -lim) sum = -lim;
        else if (sum >= lim) sum = lim;
        m_prev_err = err;
        r.drive = 16'(shr_tz(sum, 16));
        r.angle = 32'(m_angle);
        r.rate = 32'(rate);
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d", rcvd, field, got, want);
        errors++;
    endtask

    function automatic bit idle_now(input int n);
        if (n >= 700 && n < 1000) return 1'b0;
        return $urandom_range(99) < 33;
    endfunction

    // Driver
    logic v_next;
    logic we_next;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            v_next = in_valid;
            we_next = 1'b0;
            if (in_valid && !in_stall)
            begin
                predict_tilt(accel_angle, gyro_rate);
                v_next = 1'b0;
            end
            if (!v_next && pending.size() > 0)
            begin
                case (pending[0].kind)
                    K_CFG:
                        if (expected_results.size() == 0)
                        begin
                            cfg_index <= pending[0].idx;
                            cfg_data <= pending[0].data;
                            apply_cfg(pending[0].idx, pending[0].data);
                            we_next = 1'b1;
                            void'(pending.pop_front());
                        end
                    K_DRAIN:
                        if (expected_results.size() == 0)
                            void'(pending.pop_front());
                    default:
                        if (!idle_now(sent))
                        begin
                            accel_angle <= pending[0].accel;
                            gyro_rate <= pending[0].gyro;
                            v_next = 1'b1;
                            sent++;
                            void'(pending.pop_front());
                        end
                endcase
            end
            in_valid <= v_next;
            cfg_we <= we_next;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result beat %0d", rcvd);
                    errors++;
                end
                else
                begin
                    if (drive !== expected_results[0].drive)
                        report_mismatch("drive", drive, $signed(expected_results[0].drive));
                    if (filtered_angle !== expected_results[0].angle)
                        report_mismatch("filtered_angle", filtered_angle,
                                        $signed(expected_results[0].angle));
                    if (rate_estimate !== expected_results[0].rate)
                        report_mismatch("rate_estimate", rate_estimate,
                                        $signed(expected_results[0].rate));
                    void'(expected_results.pop_front());
                end
                rcvd++;
            end
            out_stall <= idle_now(rcvd);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** kalman_tilt_pid_balance_top: FAILED **");
            $finish;
        end
    end

    task automatic add_sample(input logic [ktpb_pkg::DW-1:0] a,
                              input logic [ktpb_pkg::DW-1:0] g);
        job_t j;
        j.kind = K_SAMPLE; j.accel = a; j.gyro = g; j.idx = '0; j.data = '0;
        pending.push_back(j);
    endtask

    task automatic add_cfg(input logic [ktpb_pkg::IDX_W-1:0] idx,
                           input logic [ktpb_pkg::CW-1:0] data);
        job_t j;
        j.kind = K_CFG; j.accel = '0; j.gyro = '0; j.idx = idx; j.data = data;
        pending.push_back(j);
    endtask

    task automatic add_drain();
        job_t j;
        j.kind = K_DRAIN; j.accel = '0; j.gyro = '0; j.idx = '0; j.data = '0;
        pending.push_back(j);
    endtask

    function automatic logic [ktpb_pkg::CW-1:0] reset_value(input int idx);
        case (idx)
            ktpb_pkg::REG_KP:        return ktpb_pkg::KP_RST;
            ktpb_pkg::REG_KI:        return ktpb_pkg::KI_RST;
            ktpb_pkg::REG_KD:        return ktpb_pkg::KD_RST;
            ktpb_pkg::REG_LIMIT:     return {16'd0, ktpb_pkg::LIMIT_RST};
            ktpb_pkg::REG_Q_ANGLE:   return ktpb_pkg::QA_RST;
            ktpb_pkg::REG_Q_GYRO:    return ktpb_pkg::QG_RST;
            ktpb_pkg::REG_R_ANGLE:   return ktpb_pkg::RA_RST;
            default:                 return ktpb_pkg::DT_RST;
        endcase
    endfunction

    function automatic logic [ktpb_pkg::CW-1:0] pick_cfg(input int idx);
        logic [ktpb_pkg::CW-1:0] rv;
        logic [31:0] u;
        logic [31:0] w;
        rv = reset_value(idx);
        u = $urandom;
        w = $urandom_range(32'(rv) * 2 + 1);
        case ($urandom_range(6))
            0:       return rv;
            1:       return '0;
            2:       return '1;
            3:       return u[ktpb_pkg::CW-1:0];
            default: return w[ktpb_pkg::CW-1:0];
        endcase
    endfunction

    function automatic logic [ktpb_pkg::DW-1:0] pick_value(input int span);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'($urandom_range(655360)) - 32'd327680;
            default: return 32'($urandom_range(2 * span)) - 32'(span);
        endcase
    endfunction

    int k;
    initial
    begin
        reset_model();
        add_sample(32'sd0, 32'sd0);
        add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(32'h8000_0000, 32'h8000_0000);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(32'hFFFF_FFFF, 32'h0000_0001);
        add_sample(32'h0005_0000, 32'sd0);
        add_sample(-32'sh0005_0000, 32'sd0);
        add_sample(32'h0005_0001, 32'sd0);
        add_sample(-32'sh0005_0001, 32'sd0);
        add_sample(32'h0001_8000, 32'h0010_0000);
        add_sample(32'h0064_0000, -32'sh0100_0000);
        add_drain();
        // zero angle measurement variance: no noise, no time step
        add_cfg(ktpb_pkg::REG_R_ANGLE, '0);
        add_cfg(ktpb_pkg::REG_TIME_STEP, '0);
        add_cfg(ktpb_pkg::REG_Q_ANGLE, '0);
        for (k = 0; k < 4; k++) add_sample(32'h0002_0000, 32'h0003_0000);
        add_drain();
        // drive a negative innovation variance
        add_cfg(ktpb_pkg::REG_TIME_STEP, '1);
        add_cfg(ktpb_pkg::REG_Q_ANGLE, '0);
        for (k = 0; k < 4; k++) add_sample(pick_value(2000000), pick_value(6000000));
        for (int ph = 0; ph < 10; ph++)
        begin
            add_drain();
            for (int r = 0; r < 8; r++)
                add_cfg(r[ktpb_pkg::IDX_W-1:0],
                        (ph == 0) ? '1 : (ph == 9) ? reset_value(r) : pick_cfg(r));
            if (ph == 1)
                for (int r = 0; r < 8; r++) add_cfg(r[ktpb_pkg::IDX_W-1:0], '0);
            for (int n = 0; n < 168; n++)
            begin
                add_sample(pick_value(30 << 16), pick_value(200 << 16));
                if (n == 80 && ph % 3 == 0) add_drain();
            end
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("** kalman_tilt_pid_balance_top: PASSED **");
        else
            $display("** kalman_tilt_pid_balance_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ktpb_pkg.sv
hdl/kalman_tilt_pid_balance_top.sv
tb/sv/kalman_tilt_pid_balance_top_tb.sv
